/* sv/sbir_pkg.sv */
// ----------------------------------------------------------------------------
// sbir_pkg: shared widths and register map
// Field widths, configuration register indexes and bus widths used by the
// index remap pipeline and its divider stages.
// ----------------------------------------------------------------------------
`default_nettype none

package sbir_pkg;

    // item field widths
    localparam int unsigned IDX_W  = 24;
    localparam int unsigned ADDR_W = 24;
    localparam int unsigned DIM_W  = 13;
    localparam int unsigned SB_W   = 9;
    localparam int unsigned PAD_W  = 8;

    // configuration bus
    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned REG_IDX_W  = 3;

    // register indexes (byte address is four times the index)
    localparam logic [REG_IDX_W-1:0] REG_SMALL_BATCH    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CHANNELS       = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SPACE_HEIGHT   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SPACE_WIDTH    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BLOCKED_HEIGHT = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BLOCKED_WIDTH  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_PAD_TOP        = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_PAD_LEFT       = 3'd7;

endpackage

`default_nettype wire

/* sv/space_batch_index_remap.sv */
// ----------------------------------------------------------------------------
// space_batch_index_remap: blocked-to-spatial address generator
// Maps a flat element index of the blocked NCHW tensor to the flat address in
// the spatial tensor, with an in-range flag, for space-to-batch gathers and
// batch-to-space scatters.
// ----------------------------------------------------------------------------
// The block takes one index and gives one address every clock cycle while
// the output is not held. The pipeline is four pipelined restoring dividers
// of 24 stages each (by blocked width, blocked height, channels and small
// batch), then seven stages for the division by the block size, the bounds
// check and the address multiply-adds; the last of these is the output
// register. The whole pipeline advances when the output register is empty or
// taken, so a waiting result holds everything behind it and nothing is lost.
// Registers are to be written only while the pipeline is empty. tuser on
// the input carries the mode, which does not change the mapping; tuser on
// the output is in_range, and tdata is zero whenever in_range is low.
`default_nettype none

module space_batch_index_remap #(
    parameter int unsigned BLK_DIM      = 2,
    parameter int unsigned MAX_ELEMENTS = 16777216
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // input stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [23:0]                        s_tdata,  // [23:0] elem_index
    input  wire logic                               s_tuser,  // [0] mode
    // result stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [23:0]                             m_tdata,  // [23:0] space_address
    output logic                                    m_tuser,  // [0] in_range
    // configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [sbir_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [sbir_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [sbir_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                    pready
);

    localparam int unsigned IDX_W  = sbir_pkg::IDX_W;
    localparam int unsigned ADDR_W = sbir_pkg::ADDR_W;
    localparam int unsigned DIM_W  = sbir_pkg::DIM_W;
    localparam int unsigned SB_W   = sbir_pkg::SB_W;
    localparam int unsigned PAD_W  = sbir_pkg::PAD_W;

    // offset inside the block is below BLK_DIM
    localparam int unsigned OFF_W = (BLK_DIM > 1) ? $clog2(BLK_DIM) : 1;
    // reciprocal for the block-size division, quotient low by at most one
    localparam logic [31:0] RECIP = 32'((64'd1 << 31) / BLK_DIM);
    // addresses must stay below both the memory size and the field range
    localparam longint unsigned ADDR_SPAN  = 64'd1 << ADDR_W;
    localparam longint unsigned ADDR_LIMIT =
        (64'(MAX_ELEMENTS) < ADDR_SPAN) ? 64'(MAX_ELEMENTS) : ADDR_SPAN;

    // configuration registers
    logic [SB_W-1:0]  small_batch_reg;
    logic [DIM_W-1:0] channels_reg;
    logic [DIM_W-1:0] space_height_reg;
    logic [DIM_W-1:0] space_width_reg;
    logic [DIM_W-1:0] blocked_height_reg;
    logic [DIM_W-1:0] blocked_width_reg;
    logic [PAD_W-1:0] pad_top_reg;
    logic [PAD_W-1:0] pad_left_reg;

    logic [sbir_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[sbir_pkg::REG_IDX_W+1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            small_batch_reg    <= SB_W'(1);
            channels_reg       <= DIM_W'(1);
            space_height_reg   <= DIM_W'(1);
            space_width_reg    <= DIM_W'(1);
            blocked_height_reg <= DIM_W'(1);
            blocked_width_reg  <= DIM_W'(1);
            pad_top_reg        <= '0;
            pad_left_reg       <= '0;
        end else if (cfg_write) begin
            unique case (reg_idx)
                sbir_pkg::REG_SMALL_BATCH:    small_batch_reg    <= pwdata[SB_W-1:0];
                sbir_pkg::REG_CHANNELS:       channels_reg       <= pwdata[DIM_W-1:0];
                sbir_pkg::REG_SPACE_HEIGHT:   space_height_reg   <= pwdata[DIM_W-1:0];
                sbir_pkg::REG_SPACE_WIDTH:    space_width_reg    <= pwdata[DIM_W-1:0];
                sbir_pkg::REG_BLOCKED_HEIGHT: blocked_height_reg <= pwdata[DIM_W-1:0];
                sbir_pkg::REG_BLOCKED_WIDTH:  blocked_width_reg  <= pwdata[DIM_W-1:0];
                sbir_pkg::REG_PAD_TOP:        pad_top_reg        <= pwdata[PAD_W-1:0];
                sbir_pkg::REG_PAD_LEFT:       pad_left_reg       <= pwdata[PAD_W-1:0];
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (reg_idx)
            sbir_pkg::REG_SMALL_BATCH:    prdata = 32'(small_batch_reg);
            sbir_pkg::REG_CHANNELS:       prdata = 32'(channels_reg);
            sbir_pkg::REG_SPACE_HEIGHT:   prdata = 32'(space_height_reg);
            sbir_pkg::REG_SPACE_WIDTH:    prdata = 32'(space_width_reg);
            sbir_pkg::REG_BLOCKED_HEIGHT: prdata = 32'(blocked_height_reg);
            sbir_pkg::REG_BLOCKED_WIDTH:  prdata = 32'(blocked_width_reg);
            sbir_pkg::REG_PAD_TOP:        prdata = 32'(pad_top_reg);
            sbir_pkg::REG_PAD_LEFT:       prdata = 32'(pad_left_reg);
        endcase
    end

    // divisors: a zero register divides as one
    logic [DIM_W-1:0] bw_div, bh_div, ch_div, sbatch_div;

    assign bw_div     = (blocked_width_reg == '0)  ? DIM_W'(1) : blocked_width_reg;
    assign bh_div     = (blocked_height_reg == '0) ? DIM_W'(1) : blocked_height_reg;
    assign ch_div     = (channels_reg == '0)       ? DIM_W'(1) : channels_reg;
    assign sbatch_div = (small_batch_reg == '0)    ? DIM_W'(1) : DIM_W'(small_batch_reg);

    // whole pipeline moves when the output register is free or being taken
    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // column = index mod blocked width
    logic               d1_valid;
    logic [IDX_W-1:0]   d1_quot;
    logic [DIM_W-1:0]   d1_rem;

    sbir_div #(.SIDE_W(1)) u_div_col (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (s_tvalid),
        .in_dividend (s_tdata),
        .in_divisor  (bw_div),
        .in_side     (1'b0),
        .out_valid   (d1_valid),
        .out_quot    (d1_quot),
        .out_rem     (d1_rem),
        .out_side    ()
    );

    // row = quotient mod blocked height
    logic               d2_valid;
    logic [IDX_W-1:0]   d2_quot;
    logic [DIM_W-1:0]   d2_rem;
    logic [DIM_W-1:0]   d2_side;

    sbir_div #(.SIDE_W(DIM_W)) u_div_row (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (d1_valid),
        .in_dividend (d1_quot),
        .in_divisor  (bh_div),
        .in_side     (d1_rem),
        .out_valid   (d2_valid),
        .out_quot    (d2_quot),
        .out_rem     (d2_rem),
        .out_side    (d2_side)
    );

    // channel = quotient mod channels, blocked batch = quotient
    logic               d3_valid;
    logic [IDX_W-1:0]   d3_quot;
    logic [DIM_W-1:0]   d3_rem;
    logic [2*DIM_W-1:0] d3_side;

    sbir_div #(.SIDE_W(2*DIM_W)) u_div_chan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (d2_valid),
        .in_dividend (d2_quot),
        .in_divisor  (ch_div),
        .in_side     ({d2_rem, d2_side}),
        .out_valid   (d3_valid),
        .out_quot    (d3_quot),
        .out_rem     (d3_rem),
        .out_side    (d3_side)
    );

    // small batch = blocked batch mod small_batch, block number = quotient
    logic               d4_valid;
    logic [IDX_W-1:0]   d4_quot;
    logic [DIM_W-1:0]   d4_rem;
    logic [3*DIM_W-1:0] d4_side;

    sbir_div #(.SIDE_W(3*DIM_W)) u_div_batch (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (d3_valid),
        .in_dividend (d3_quot),
        .in_divisor  (sbatch_div),
        .in_side     ({d3_rem, d3_side}),
        .out_valid   (d4_valid),
        .out_quot    (d4_quot),
        .out_rem     (d4_rem),
        .out_side    (d4_side)
    );

    // stage a: reciprocal product for the block split, batch times channels
    logic                   a_valid_reg;
    logic [55:0]            a_prod_reg;
    logic [IDX_W-1:0]       a_blk_reg;
    logic [SB_W+DIM_W-1:0]  a_base_reg;
    logic [DIM_W-1:0]       a_chan_reg, a_row_reg, a_col_reg;

    // stage b: corrected block offsets, base plus channel
    logic                   b_valid_reg;
    logic [IDX_W-1:0]       b_off_h_reg;
    logic [OFF_W-1:0]       b_off_w_reg;
    logic [SB_W+DIM_W:0]    b_base_reg;
    logic [DIM_W-1:0]       b_row_reg, b_col_reg;

    logic [IDX_W-1:0]       blk_q;
    logic [IDX_W+2:0]       blk_r;
    logic [IDX_W-1:0]       b_off_h_next;
    logic [OFF_W-1:0]       b_off_w_next;

    always_comb begin
        blk_q = a_prod_reg[54:31];
        blk_r = (IDX_W+3)'(a_blk_reg) - (IDX_W+3)'(blk_q) * (IDX_W+3)'(BLK_DIM);
        if (blk_r >= (IDX_W+3)'(BLK_DIM)) begin
            b_off_h_next = blk_q + IDX_W'(1);
            b_off_w_next = OFF_W'(blk_r - (IDX_W+3)'(BLK_DIM));
        end else begin
            b_off_h_next = blk_q;
            b_off_w_next = OFF_W'(blk_r);
        end
    end

    // stage c: padded position, padding removed, bounds check
    logic                   c_valid_reg;
    logic                   c_ok_reg;
    logic [DIM_W-1:0]       c_srow_reg, c_scol_reg;
    logic [SB_W+DIM_W:0]    c_base_reg;

    logic [IDX_W:0]         row_sum;
    logic [IDX_W+1:0]       srow;
    logic [16:0]            col_sum;
    logic [17:0]            scol;
    logic                   c_ok_next;

    always_comb begin
        row_sum = (IDX_W+1)'(b_row_reg) * (IDX_W+1)'(BLK_DIM)
                + (IDX_W+1)'(b_off_h_reg);
        srow    = {1'b0, row_sum} - (IDX_W+2)'(pad_top_reg);
        col_sum = 17'(b_col_reg) * 17'(BLK_DIM) + 17'(b_off_w_reg);
        scol    = {1'b0, col_sum} - 18'(pad_left_reg);
        c_ok_next = !srow[IDX_W+1] && !scol[17]
                 && (srow[IDX_W:0] < (IDX_W+1)'(space_height_reg))
                 && (scol[16:0] < 17'(space_width_reg));
    end

    // stage d: times space height
    logic                   d_valid_reg;
    logic                   d_ok_reg;
    logic [35:0]            d_m1_reg;
    logic [DIM_W-1:0]       d_srow_reg, d_scol_reg;

    // stage e: plus row, checked against the address range
    logic                   e_valid_reg;
    logic                   e_ok_reg;
    logic [ADDR_W-1:0]      e_a1_reg;
    logic [DIM_W-1:0]       e_scol_reg;
    logic [36:0]            sum1;

    assign sum1 = 37'(d_m1_reg) + 37'(d_srow_reg);

    // stage f: times space width
    logic                   f_valid_reg;
    logic                   f_ok_reg;
    logic [36:0]            f_m2_reg;
    logic [DIM_W-1:0]       f_scol_reg;

    // output stage: plus column, final limit check
    logic [ADDR_W-1:0]      out_addr_reg;
    logic                   out_range_reg;
    logic [37:0]            sum2;
    logic                   out_ok;

    assign sum2   = 38'(f_m2_reg) + 38'(f_scol_reg);
    assign out_ok = f_ok_reg && (sum2 < 38'(ADDR_LIMIT));

    // valid bits of the tail stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            f_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg   <= d4_valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= c_valid_reg;
            e_valid_reg   <= d_valid_reg;
            f_valid_reg   <= e_valid_reg;
            out_valid_reg <= f_valid_reg;
        end
    end

    // payload of the tail stages
    always_ff @(posedge aclk) begin
        if (en) begin
            a_prod_reg    <= 56'(d4_quot) * 56'(RECIP);
            a_blk_reg     <= d4_quot;
            a_base_reg    <= (SB_W+DIM_W)'(d4_rem[SB_W-1:0]) * (SB_W+DIM_W)'(ch_div);
            a_chan_reg    <= d4_side[3*DIM_W-1:2*DIM_W];
            a_row_reg     <= d4_side[2*DIM_W-1:DIM_W];
            a_col_reg     <= d4_side[DIM_W-1:0];

            b_off_h_reg   <= b_off_h_next;
            b_off_w_reg   <= b_off_w_next;
            b_base_reg    <= (SB_W+DIM_W+1)'(a_base_reg) + (SB_W+DIM_W+1)'(a_chan_reg);
            b_row_reg     <= a_row_reg;
            b_col_reg     <= a_col_reg;

            c_ok_reg      <= c_ok_next;
            c_srow_reg    <= srow[DIM_W-1:0];
            c_scol_reg    <= scol[DIM_W-1:0];
            c_base_reg    <= b_base_reg;

            d_ok_reg      <= c_ok_reg;
            d_m1_reg      <= 36'(c_base_reg) * 36'(space_height_reg);
            d_srow_reg    <= c_srow_reg;
            d_scol_reg    <= c_scol_reg;

            e_ok_reg      <= d_ok_reg && (sum1[36:ADDR_W] == '0);
            e_a1_reg      <= sum1[ADDR_W-1:0];
            e_scol_reg    <= d_scol_reg;

            f_ok_reg      <= e_ok_reg;
            f_m2_reg      <= 37'(e_a1_reg) * 37'(space_width_reg);
            f_scol_reg    <= e_scol_reg;

            out_range_reg <= out_ok;
            out_addr_reg  <= out_ok ? sum2[ADDR_W-1:0] : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_addr_reg;
    assign m_tuser  = out_range_reg;

endmodule

`default_nettype wire

/* sv/sbir_div.sv */
// ----------------------------------------------------------------------------
// sbir_div: pipelined restoring divider
// Divides an index-wide dividend by a static divisor, one quotient bit per
// register stage, and carries a sideband word alongside each transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module sbir_div #(
    parameter int unsigned SIDE_W = 1
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [sbir_pkg::IDX_W-1:0]    in_dividend,
    input  wire logic [sbir_pkg::DIM_W-1:0]    in_divisor,
    input  wire logic [SIDE_W-1:0]             in_side,
    output logic                               out_valid,
    output logic [sbir_pkg::IDX_W-1:0]         out_quot,
    output logic [sbir_pkg::DIM_W-1:0]         out_rem,
    output logic [SIDE_W-1:0]                  out_side
);

    localparam int unsigned N = sbir_pkg::IDX_W;
    localparam int unsigned D = sbir_pkg::DIM_W;

    logic             valid_reg [N];
    logic [D-1:0]     rem_reg   [N];
    logic [N-1:0]     work_reg  [N];
    logic [SIDE_W-1:0] side_reg [N];

    logic [D-1:0]     rem_in    [N];
    logic [N-1:0]     work_in   [N];
    logic [D-1:0]     rem_next  [N];
    logic [N-1:0]     work_next [N];

    // stage inputs: the first stage takes the port, the rest the previous stage
    always_comb begin
        rem_in[0]  = '0;
        work_in[0] = in_dividend;
        for (int k = 1; k < N; k++) begin
            rem_in[k]  = rem_reg[k-1];
            work_in[k] = work_reg[k-1];
        end
    end

    // one trial subtraction per stage; quotient bits shift in at the bottom
    always_comb begin
        logic [D:0] trial;
        logic       ge;
        for (int k = 0; k < N; k++) begin
            trial        = {rem_in[k], work_in[k][N-1]};
            ge           = (trial >= {1'b0, in_divisor});
            rem_next[k]  = ge ? D'(trial - {1'b0, in_divisor}) : D'(trial);
            work_next[k] = {work_in[k][N-2:0], ge};
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < N; k++) valid_reg[k] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < N; k++) valid_reg[k] <= valid_reg[k-1];
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_side;
            for (int k = 1; k < N; k++) side_reg[k] <= side_reg[k-1];
            for (int k = 0; k < N; k++) begin
                rem_reg[k]  <= rem_next[k];
                work_reg[k] <= work_next[k];
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_quot  = work_reg[N-1];
    assign out_rem   = rem_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

`default_nettype wire

/* bench/sbir_checker.sv */
// ----------------------------------------------------------------------------
// sbir_checker: result checker for the index remap pipeline
// Watches the configuration port and both streams, keeps its own copy of the
// register file, works out the spatial address and in-range flag for every
// index transfer and compares each result transfer with the oldest one due.
// ----------------------------------------------------------------------------
`default_nettype none

module sbir_checker
    import sbir_pkg::*;
#(
    parameter int unsigned BLK_DIM      = 2,
    parameter int unsigned MAX_ELEMENTS = 16777216
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input stream
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [IDX_W-1:0]      s_tdata,   // [23:0] elem_index
    input  wire logic                  s_tuser,   // [0] mode
    // result stream
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [ADDR_W-1:0]     m_tdata,   // [23:0] space_address
    input  wire logic                  m_tuser,   // [0] in_range
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    input  wire logic                  pready,
    // status for the top
    output int                         fail_count,
    output int                         pending_results,
    output int                         results_seen,
    output int                         in_range_seen
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              in_range;
    } space_ref_t;

    // shadow register file
    logic [SB_W-1:0]  cfg_small_batch;
    logic [DIM_W-1:0] cfg_channels;
    logic [DIM_W-1:0] cfg_space_height;
    logic [DIM_W-1:0] cfg_space_width;
    logic [DIM_W-1:0] cfg_blocked_height;
    logic [DIM_W-1:0] cfg_blocked_width;
    logic [PAD_W-1:0] cfg_pad_top;
    logic [PAD_W-1:0] cfg_pad_left;

    space_ref_t space_addr_q[$];

    // one line per mismatch, and count it
    task automatic note_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    // blocked index -> spatial address under the current register values
    function automatic space_ref_t map_blocked_index(input logic [IDX_W-1:0] idx);
        longint unsigned sbn, chn, bhn, bwn;
        longint unsigned col, row, chan, bb, sb, blk, off_w, off_h, t, addr;
        longint          srow, scol;
        space_ref_t      r;
        // zero divisors behave as one
        sbn = (cfg_small_batch == 0) ? 1 : cfg_small_batch;
        chn = (cfg_channels == 0) ? 1 : cfg_channels;
        bhn = (cfg_blocked_height == 0) ? 1 : cfg_blocked_height;
        bwn = (cfg_blocked_width == 0) ? 1 : cfg_blocked_width;
        col = idx % bwn;
        t = idx / bwn;
        row = t % bhn;
        t = t / bhn;
        chan = t % chn;
        bb = t / chn;
        sb = bb % sbn;
        blk = bb / sbn;
        off_w = blk % BLK_DIM;
        off_h = blk / BLK_DIM;
        srow = longint'(row * BLK_DIM + off_h) - longint'(cfg_pad_top);
        scol = longint'(col * BLK_DIM + off_w) - longint'(cfg_pad_left);
        r.addr = '0;
        r.in_range = 1'b0;
        if (srow >= 0 && scol >= 0 && srow < longint'(cfg_space_height)
                && scol < longint'(cfg_space_width)) begin
            addr = ((sb * chn + chan) * cfg_space_height + longint'(srow))
                   * cfg_space_width + longint'(scol);
            // addresses past the memory are treated as out of range
            if (addr < MAX_ELEMENTS && addr <= 64'hFF_FFFF) begin
                r.addr = addr[ADDR_W-1:0];
                r.in_range = 1'b1;
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        space_ref_t want;
        if (!aresetn) begin
            cfg_small_batch    = 1;
            cfg_channels       = 1;
            cfg_space_height   = 1;
            cfg_space_width    = 1;
            cfg_blocked_height = 1;
            cfg_blocked_width  = 1;
            cfg_pad_top        = 0;
            cfg_pad_left       = 0;
            space_addr_q.delete();
        end else begin
            // index transfer: queue what it should produce
            if (s_tvalid && s_tready)
                space_addr_q.push_back(map_blocked_index(s_tdata));

            // result transfer: compare with the oldest outstanding one
            if (m_tvalid && m_tready) begin
                if (space_addr_q.size() == 0) begin
                    note_mismatch($sformatf("result with none due: addr %h in_range %b",
                                            m_tdata, m_tuser));
                end else begin
                    want = space_addr_q.pop_front();
                    if (m_tdata !== want.addr)
                        note_mismatch($sformatf("space_address %h, expected %h",
                                                m_tdata, want.addr));
                    if (m_tuser !== want.in_range)
                        note_mismatch($sformatf("in_range %b, expected %b",
                                                m_tuser, want.in_range));
                    results_seen++;
                    if (want.in_range)
                        in_range_seen++;
                end
            end

            // register write
            if (psel && penable && pwrite && pready) begin
                case (paddr[APB_ADDR_W-1:2])
                    REG_SMALL_BATCH:    cfg_small_batch    = pwdata[SB_W-1:0];
                    REG_CHANNELS:       cfg_channels       = pwdata[DIM_W-1:0];
                    REG_SPACE_HEIGHT:   cfg_space_height   = pwdata[DIM_W-1:0];
                    REG_SPACE_WIDTH:    cfg_space_width    = pwdata[DIM_W-1:0];
                    REG_BLOCKED_HEIGHT: cfg_blocked_height = pwdata[DIM_W-1:0];
                    REG_BLOCKED_WIDTH:  cfg_blocked_width  = pwdata[DIM_W-1:0];
                    REG_PAD_TOP:        cfg_pad_top        = pwdata[PAD_W-1:0];
                    REG_PAD_LEFT:       cfg_pad_left       = pwdata[PAD_W-1:0];
                    default: ;
                endcase
            end
        end
        pending_results = space_addr_q.size();
    end

endmodule

`default_nettype wire

/* bench/tb_space_batch_index_remap.sv */
// ----------------------------------------------------------------------------
// tb_space_batch_index_remap: testbench for the index remap pipeline
// Programs a series of tensor shapes over the configuration port, drives
// directed and random element indices with random gaps on both streams and a
// long output hold-off, and leaves the checking to sbir_checker.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_space_batch_index_remap;

    timeunit 1ns;
    timeprecision 1ps;

    import sbir_pkg::*;

    localparam int unsigned BLK_DIM      = 2;
    localparam int unsigned MAX_ELEMENTS = 16777216;
    localparam int PIPE_LATENCY = 103;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int RAND_PHASES  = 7;
    localparam int DIM_MAX      = 8191;
    localparam int SB_MAX       = 511;
    localparam int PAD_MAX      = 255;

    typedef struct {
        int sb, ch, sh, sw, bh, bw, pt, pl;
    } tensor_shape_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IDX_W-1:0]      s_tdata;   // [23:0] elem_index
    logic                  s_tuser;   // [0] mode
    logic                  m_tvalid;
    logic                  m_tready;
    logic [ADDR_W-1:0]     m_tdata;   // [23:0] space_address
    logic                  m_tuser;   // [0] in_range
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending_results;
    int results_seen;
    int in_range_seen;

    // traffic shaping shared with the receiver
    int src_gap_pct;
    int sink_gap_pct;
    bit long_hold;

    int items_sent;
    int settings_used;
    int idle_cycles;
    tensor_shape_t cur_shape;

    space_batch_index_remap #(
        .BLK_DIM     (BLK_DIM),
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    sbir_checker #(
        .BLK_DIM     (BLK_DIM),
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .fail_count     (fail_count),
        .pending_results(pending_results),
        .results_seen   (results_seen),
        .in_range_seen  (in_range_seen)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, pending_results);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result receiver: random stalls and one long hold-off on request
    initial begin : sink
        int gap;
        bit hold_done;
        hold_done = 1'b0;
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold && !hold_done) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
                m_tready = 1'b1;
            end else if (sink_gap_pct != 0 && $urandom_range(0, 99) < sink_gap_pct) begin
                gap = $urandom_range(1, 15);
                m_tready = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // one register write: setup then access
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int value);
        @(negedge aclk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic apply_shape(input tensor_shape_t shp);
        write_reg(REG_SMALL_BATCH, shp.sb);
        write_reg(REG_CHANNELS, shp.ch);
        write_reg(REG_SPACE_HEIGHT, shp.sh);
        write_reg(REG_SPACE_WIDTH, shp.sw);
        write_reg(REG_BLOCKED_HEIGHT, shp.bh);
        write_reg(REG_BLOCKED_WIDTH, shp.bw);
        write_reg(REG_PAD_TOP, shp.pt);
        write_reg(REG_PAD_LEFT, shp.pl);
        cur_shape = shp;
        settings_used++;
    endtask

    // offer one index transfer, with an optional gap ahead of it
    task automatic push_index(input logic mode, input logic [IDX_W-1:0] idx);
        int gap;
        @(negedge aclk);
        if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
            gap = $urandom_range(1, 15);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = idx;
        s_tuser = mode;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // stop offering and wait for every outstanding result
    task automatic settle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_results != 0) @(negedge aclk);
    endtask

    function automatic int nz(input int v);
        return (v == 0) ? 1 : v;
    endfunction

    // mostly modest sizes, now and then zero or all ones
    function automatic int pick_dim(input int lo, input int hi, input int maxv);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 0;
        if (r == 1)
            return maxv;
        return $urandom_range(lo, (hi > maxv) ? maxv : hi);
    endfunction

    function automatic tensor_shape_t pick_shape();
        tensor_shape_t shp;
        shp.sb = pick_dim(1, 4, SB_MAX);
        shp.ch = pick_dim(1, 6, DIM_MAX);
        shp.bh = pick_dim(1, 12, DIM_MAX);
        shp.bw = pick_dim(1, 12, DIM_MAX);
        shp.pt = pick_dim(0, 3, PAD_MAX);
        shp.pl = pick_dim(0, 3, PAD_MAX);
        // spatial extent close to twice the blocked one so many land in range
        shp.sh = pick_dim(1, 2 * nz(shp.bh) + 2, DIM_MAX);
        shp.sw = pick_dim(1, 2 * nz(shp.bw) + 2, DIM_MAX);
        return shp;
    endfunction

    // index mostly inside the blocked tensor, some just past it, some anywhere
    function automatic logic [IDX_W-1:0] pick_index(input tensor_shape_t shp);
        longint unsigned span;
        int r;
        span = longint'(nz(shp.sb)) * nz(shp.ch) * nz(shp.bh) * nz(shp.bw)
               * BLK_DIM * BLK_DIM;
        if (span > 64'h100_0000)
            span = 64'h100_0000;
        r = $urandom_range(0, 9);
        if (r < 7)
            return IDX_W'($urandom_range(0, int'(span - 1)));
        if (r == 7)
            return IDX_W'(span + $urandom_range(0, 3));
        return IDX_W'($urandom());
    endfunction

    initial begin : stimulus
        tensor_shape_t shp;
        int n;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        src_gap_pct = 0;
        sink_gap_pct = 0;
        long_hold = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        // reset values: one-element tensor
        push_index(1'b0, 24'd0);
        push_index(1'b1, 24'd1);
        push_index(1'b0, 24'd2);
        push_index(1'b1, 24'hFF_FFFF);
        settle();

        // small shape with top padding, inside and past the blocked tensor
        shp = '{sb: 2, ch: 3, sh: 5, sw: 6, bh: 3, bw: 3, pt: 1, pl: 0};
        apply_shape(shp);
        push_index(1'b0, 24'd0);
        push_index(1'b1, 24'd1);
        push_index(1'b0, 24'd4);
        push_index(1'b1, 24'd9);
        push_index(1'b0, 24'd58);
        push_index(1'b1, 24'd107);
        push_index(1'b0, 24'd215);
        push_index(1'b1, 24'd216);
        push_index(1'b0, 24'h55_5555);
        push_index(1'b1, 24'hAA_AAAA);
        settle();

        // zero registers: divisors act as one, no spatial extent
        shp = '{sb: 0, ch: 0, sh: 0, sw: 0, bh: 0, bw: 0, pt: 0, pl: 0};
        apply_shape(shp);
        push_index(1'b0, 24'd0);
        push_index(1'b1, 24'd5);
        push_index(1'b0, 24'hFF_FFFF);
        settle();

        // every register at its maximum
        shp = '{sb: SB_MAX, ch: DIM_MAX, sh: DIM_MAX, sw: DIM_MAX,
                bh: DIM_MAX, bw: DIM_MAX, pt: PAD_MAX, pl: PAD_MAX};
        apply_shape(shp);
        push_index(1'b1, 24'd0);
        push_index(1'b0, 24'hFF_FFFF);
        push_index(1'b1, 24'h80_0000);
        settle();

        // in-bounds positions whose address passes the end of memory
        shp = '{sb: 4, ch: 4096, sh: 4096, sw: 4096, bh: 1, bw: 1, pt: 0, pl: 0};
        apply_shape(shp);
        push_index(1'b0, 24'd0);
        push_index(1'b1, 24'd1);
        push_index(1'b0, 24'd4095);
        push_index(1'b1, 24'd16384);
        settle();

        // random shapes and indices; one phase fills the pipe behind a hold-off
        for (int p = 0; p < RAND_PHASES; p++) begin
            apply_shape(pick_shape());
            if (p == RAND_PHASES - 1) begin
                src_gap_pct = 0;
                sink_gap_pct = 0;
            end else begin
                src_gap_pct = 15 * $urandom_range(0, 3);
                sink_gap_pct = 15 * $urandom_range(0, 3);
            end
            n = 100;
            if (p == 2) begin
                long_hold = 1'b1;
                n = 200;
            end
            repeat (n) push_index(1'($urandom_range(0, 1)), pick_index(cur_shape));
            settle();
        end

        repeat (PIPE_LATENCY + 16) @(negedge aclk);
        $display("covered %0d index transfers over %0d register settings, both modes",
                 items_sent, settings_used);
        $display("%0d results checked, %0d in range, %0d zero-fill or drop",
                 results_seen, in_range_seen, results_seen - in_range_seen);
        if (fail_count == 0 && pending_results == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
